// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/xcd_pkg.sv =====
// Package: constants, types and helpers of the command frame deframer.
package xcd_pkg;

  localparam int unsigned XCD_PAYLOAD_BYTES_KEPT = 6;
  localparam int unsigned PAYLOAD_W = 48;

  localparam logic [7:0] HDR0    = 8'hEB;
  localparam logic [7:0] HDR1    = 8'h53;
  localparam logic [7:0] MIN_LEN = 8'd5;

  typedef enum logic [1:0] {
    ST_GOOD_KNOWN   = 2'd0,
    ST_GOOD_UNKNOWN = 2'd1,
    ST_CHECK_ERR    = 2'd2,
    ST_TOO_SHORT    = 2'd3
  } xcd_status_t;

  typedef enum logic [5:0] {
    PH_HUNT  = 6'b000001,
    PH_HDR1  = 6'b000010,
    PH_LEN   = 6'b000100,
    PH_CMD   = 6'b001000,
    PH_DATA  = 6'b010000,
    PH_CHECK = 6'b100000
  } xcd_phase_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } xcd_item_t;

  function automatic logic known_command(input logic [7:0] c);
    return c inside {[8'h01:8'h14], [8'h20:8'h22], 8'h24, [8'h30:8'h32]};
  endfunction

endpackage

// ===== rtl/xor_checked_command_deframer_core.sv =====
// Top level of the XOR-checked serial command frame deframer.
// Takes one received byte per cycle and reports one request per frame (or per
// rejected short length byte) on the result channel. Throughput is one byte
// every cycle, set by the single parser state update between the input
// register and the result register, which the byte that ends a frame passes
// in that order. Input is held off only while a result waits on a low
// res_ready with a byte already in the input register.
module xor_checked_command_deframer_core import xcd_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES_KEPT = XCD_PAYLOAD_BYTES_KEPT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rx_valid,
  output logic                 rx_ready,
  input  logic [7:0]           rx_byte,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [1:0]           status,
  output logic [7:0]           command,
  output logic [7:0]           frame_length,
  output logic [PAYLOAD_W-1:0] payload,
  output logic [7:0]           payload_count
);

  xcd_item_t item;
  logic      advance;

  xcd_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_ready (rx_ready),
    .rx_byte  (rx_byte),
    .advance  (advance),
    .item     (item)
  );

  xcd_parser #(
    .PAYLOAD_BYTES_KEPT (PAYLOAD_BYTES_KEPT)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .item          (item),
    .advance       (advance),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .status        (status),
    .command       (command),
    .frame_length  (frame_length),
    .payload       (payload),
    .payload_count (payload_count)
  );

endmodule

// ===== rtl/xcd_in_stage.sv =====
// Input register stage: holds one received byte until the parser takes it.
module xcd_in_stage import xcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output xcd_item_t  item
);

  assign rx_ready = !item.valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (rx_ready) begin
      item.valid <= rx_valid;
    end
    if (rx_valid && rx_ready) begin
      item.rx_byte <= rx_byte;
    end
  end

endmodule

// ===== rtl/xcd_parser.sv =====
// Frame parser: header hunt, length, command, payload and XOR check, result register.
module xcd_parser import xcd_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES_KEPT = XCD_PAYLOAD_BYTES_KEPT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  xcd_item_t            item,
  output logic                 advance,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [1:0]           status,
  output logic [7:0]           command,
  output logic [7:0]           frame_length,
  output logic [PAYLOAD_W-1:0] payload,
  output logic [7:0]           payload_count
);

  localparam int unsigned StoreW = 8 * PAYLOAD_BYTES_KEPT;

  xcd_phase_t        phase, phase_next;
  logic [7:0]        byte_position, byte_position_next;
  logic [7:0]        length_seen, length_seen_next;
  logic [7:0]        command_seen, command_seen_next;
  logic [7:0]        running_xor, running_xor_next;
  logic [StoreW-1:0] payload_store, payload_store_next;

  logic                        fire;
  logic                        emit;
  logic [7:0]                  b;
  logic [7:0]                  pos_inc;
  logic [StoreW+PAYLOAD_W-1:0] payload_ext;
  xcd_status_t                 r_status;
  logic [7:0]                  r_command;
  logic [7:0]                  r_length;
  logic [PAYLOAD_W-1:0]        r_payload;
  logic [7:0]                  r_count;

  assign advance     = !res_valid || res_ready;
  assign fire        = item.valid && advance;
  assign b           = item.rx_byte;
  assign pos_inc     = byte_position + 8'd1;
  assign payload_ext = {{PAYLOAD_W{1'b0}}, payload_store};

  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    length_seen_next   = length_seen;
    command_seen_next  = command_seen;
    running_xor_next   = running_xor;
    payload_store_next = payload_store;
    emit               = 1'b0;
    r_status           = ST_GOOD_KNOWN;
    r_command          = command_seen;
    r_length           = length_seen;
    r_payload          = payload_ext[PAYLOAD_W-1:0];
    r_count            = length_seen - MIN_LEN;
    if (fire) begin
      case (phase)
        PH_HUNT: begin
          if (b == HDR0) phase_next = PH_HDR1;
        end
        PH_HDR1: begin
          if (b == HDR1) phase_next = PH_LEN;
          else if (b != HDR0) phase_next = PH_HUNT;
        end
        PH_LEN: begin
          length_seen_next = b;
          if (b < MIN_LEN) begin
            emit       = 1'b1;
            r_status   = ST_TOO_SHORT;
            r_command  = 8'd0;
            r_length   = b;
            r_payload  = '0;
            r_count    = 8'd0;
            phase_next = PH_HUNT;
          end else begin
            phase_next = PH_CMD;
          end
        end
        PH_CMD: begin
          command_seen_next  = b;
          running_xor_next   = b;
          byte_position_next = 8'd0;
          payload_store_next = '0;
          phase_next = (length_seen == MIN_LEN) ? PH_CHECK : PH_DATA;
        end
        PH_DATA: begin
          running_xor_next = running_xor ^ b;
          for (int i = 0; i < PAYLOAD_BYTES_KEPT; i++) begin
            if (byte_position == 8'(i)) begin
              payload_store_next[8*(PAYLOAD_BYTES_KEPT-1-i) +: 8] = b;
            end
          end
          byte_position_next = pos_inc;
          if (pos_inc == length_seen - MIN_LEN) phase_next = PH_CHECK;
        end
        PH_CHECK: begin
          emit = 1'b1;
          if (b != running_xor) r_status = ST_CHECK_ERR;
          else if (known_command(command_seen)) r_status = ST_GOOD_KNOWN;
          else r_status = ST_GOOD_UNKNOWN;
          phase_next = PH_HUNT;
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HUNT;
      res_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (advance) res_valid <= emit;
    end
    byte_position <= byte_position_next;
    length_seen   <= length_seen_next;
    command_seen  <= command_seen_next;
    running_xor   <= running_xor_next;
    payload_store <= payload_store_next;
    if (emit) begin
      status        <= r_status;
      command       <= r_command;
      frame_length  <= r_length;
      payload       <= r_payload;
      payload_count <= r_count;
    end
  end

endmodule

// ===== rtl/xcd_checker.sv =====
// Port-level checker for the deframer, bound to the top level.
`include "assert_macros.svh"

module xcd_checker import xcd_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 rx_ready,
  input logic                 res_valid,
  input logic                 res_ready,
  input logic [1:0]           status,
  input logic [7:0]           command,
  input logic [7:0]           frame_length,
  input logic [PAYLOAD_W-1:0] payload,
  input logic [7:0]           payload_count
);

  logic                  res_stall;
  logic                  res_short;
  logic                  res_frame;
  logic                  short_ok;
  logic                  frame_ok;
  logic [PAYLOAD_W+25:0] res_fields;

  assign res_stall  = res_valid && !res_ready;
  assign res_short  = res_valid && status == ST_TOO_SHORT;
  assign res_frame  = res_valid && status != ST_TOO_SHORT;
  assign short_ok   = command == 8'd0 && payload == '0 && payload_count == 8'd0
                      && frame_length < MIN_LEN;
  assign frame_ok   = frame_length >= MIN_LEN && payload_count == frame_length - MIN_LEN;
  assign res_fields = {status, command, frame_length, payload, payload_count};

  `ASSERT_NEXT(res_hold, clk, rst, res_stall, res_valid && $stable(res_fields))
  `ASSERT_IMPLIES(short_fields, clk, rst, res_short, short_ok)
  `ASSERT_IMPLIES(frame_count, clk, rst, res_frame, frame_ok)
  `ASSERT_IMPLIES(stall_cause, clk, rst, !rx_ready, res_stall)

endmodule

bind xor_checked_command_deframer_core xcd_checker u_xcd_checker (
  .clk           (clk),
  .rst           (rst),
  .rx_ready      (rx_ready),
  .res_valid     (res_valid),
  .res_ready     (res_ready),
  .status        (status),
  .command       (command),
  .frame_length  (frame_length),
  .payload       (payload),
  .payload_count (payload_count)
);
